### design/b64_pkg.sv
package b64_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'd61;  // '='
   localparam logic [7:0] PLUS_CHAR  = 8'd43;  // '+'
   localparam logic [7:0] SLASH_CHAR = 8'd47;  // '/'
   localparam int         SEXTET_W   = 6;
   localparam int         MAX_WORDS  = 4;

   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_in;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_out;
      logic       empty_res;
      logic       bad_char;
   } rsp_type;

   typedef struct packed {
      logic [SEXTET_W-1:0] leftover_bits;
      logic [1:0]          group_phase;
      logic                pad_seen;
   } state_type;

   typedef struct packed {
      state_type                   nxt;
      rsp_type [MAX_WORDS-1:0]     words;
      logic [2:0]                  count;
   } step_type;

   // 6-bit value to alphabet character
   function automatic logic [7:0] sym_of(input logic [SEXTET_W-1:0] v);
      logic [7:0] ch;
      if (v < 6'd26)      ch = {2'b00, v} + 8'd65;
      else if (v < 6'd52) ch = {2'b00, v} + 8'd71;
      else if (v < 6'd62) ch = {2'b00, v} - 8'd4;
      else if (v == 6'd62) ch = PLUS_CHAR;
      else                ch = SLASH_CHAR;
      return ch;
   endfunction

   // character to {invalid, 6-bit value}
   function automatic logic [SEXTET_W:0] val_of(input logic [7:0] c);
      logic [7:0] d;
      logic [SEXTET_W:0] r;
      d = 8'd0;
      r = {1'b1, 6'd0};
      if (c >= 8'd65 && c <= 8'd90) begin
         d = c - 8'd65;
         r = {1'b0, d[5:0]};
      end else if (c >= 8'd97 && c <= 8'd122) begin
         d = c - 8'd71;
         r = {1'b0, d[5:0]};
      end else if (c >= 8'd48 && c <= 8'd57) begin
         d = c + 8'd4;
         r = {1'b0, d[5:0]};
      end else if (c == PLUS_CHAR) begin
         r = {1'b0, 6'd62};
      end else if (c == SLASH_CHAR) begin
         r = {1'b0, 6'd63};
      end
      return r;
   endfunction

endpackage

### design/base64_codec.sv
// base64_codec: streaming base64 encoder/decoder, direction set by register 0.
// A word goes from the input register to the group buffer, then the output register.
// Throughput: one input word per cycle when it yields at most one result and the
// result channel is not stalled; the result channel moves one word per cycle.
// Reset (synchronous, active high) clears all pipeline valids, the run state and
// sets direction to encode.
module base64_codec (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  b64_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output b64_pkg::rsp_type rsp_word,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import b64_pkg::*;

   // input register
   logic      in_valid_ff, in_valid_in;
   req_type   in_word_ff, in_word_in;

   // run state and direction register
   state_type st_ff, st_in;
   logic      dir_ff, dir_in;

   // group buffer: up to four result words, head at index 0
   rsp_type [MAX_WORDS-1:0] grp_ff, grp_in;
   logic [2:0]              grp_cnt_ff, grp_cnt_in;

   // output register
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_word_ff, rsp_word_in;

   step_type  step;
   logic      out_load, grp_pop, grp_load, in_load, cfg_wr;

   b64_step u_step (
      .dir  (dir_ff),
      .st   (st_ff),
      .item (in_word_ff),
      .res  (step)
   );

   // output register takes a word whenever it is empty or being drained
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign grp_pop  = out_load && (grp_cnt_ff != 3'd0);
   // group buffer refills once its last word leaves
   assign grp_load = in_valid_ff &&
                     ((grp_cnt_ff == 3'd0) || ((grp_cnt_ff == 3'd1) && grp_pop));
   assign in_load  = !in_valid_ff || grp_load;
   assign req_stall = !in_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // APB: addresses 0 to 3 (paddr[2] low) all map to register 0 (direction); writes elsewhere are ignored
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
   assign prdata = (paddr[2] == 1'b0) ? {31'd0, dir_ff} : 32'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (in_load) begin
         in_valid_in = req_valid;
         in_word_in  = req_word;
      end
   end

   always_comb begin
      st_in  = st_ff;
      dir_in = dir_ff;
      if (cfg_wr) begin
         // any direction write starts a fresh run
         dir_in = pwdata[0];
         st_in  = '0;
      end else if (grp_load) begin
         st_in = step.nxt;
      end
   end

   always_comb begin
      grp_in     = grp_ff;
      grp_cnt_in = grp_cnt_ff;
      if (grp_load) begin
         grp_in     = step.words;
         grp_cnt_in = step.count;
      end else if (grp_pop) begin
         for (int k = 0; k < MAX_WORDS - 1; k++) begin
            grp_in[k] = grp_ff[k + 1];
         end
         grp_in[MAX_WORDS-1] = '0;
         grp_cnt_in = grp_cnt_ff - 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (out_load) begin
         rsp_valid_in = (grp_cnt_ff != 3'd0);
         rsp_word_in  = grp_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         st_ff        <= '0;
         dir_ff       <= DIR_ENCODE;
         grp_cnt_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         st_ff        <= st_in;
         dir_ff       <= dir_in;
         grp_cnt_ff   <= grp_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      grp_ff      <= grp_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

### design/b64_step.sv
module b64_step (
   input  logic               dir,
   input  b64_pkg::state_type st,
   input  b64_pkg::req_type   item,
   output b64_pkg::step_type  res
);
   import b64_pkg::*;

   logic [7:0]          b;
   logic [SEXTET_W:0]   vv;
   logic [SEXTET_W-1:0] v;
   logic                bad;
   logic                have;
   logic [2:0]          n;

   assign b = item.in_byte;

   always_comb begin
      res  = '0;
      res.nxt = st;
      vv   = val_of(b);
      v    = vv[SEXTET_W] ? '0 : vv[SEXTET_W-1:0];
      bad  = 1'b0;
      have = 1'b0;
      n    = 3'd0;
      if (dir == DIR_ENCODE) begin
         case (st.group_phase)
            2'd0: begin
               res.words[0].out_byte = sym_of(b[7:2]);
               res.nxt.leftover_bits = {b[1:0], 4'b0000};
               res.nxt.group_phase   = 2'd1;
               n = 3'd1;
            end
            2'd1: begin
               res.words[0].out_byte = sym_of(st.leftover_bits | {2'b00, b[7:4]});
               res.nxt.leftover_bits = {b[3:0], 2'b00};
               res.nxt.group_phase   = 2'd2;
               n = 3'd1;
            end
            default: begin
               res.words[0].out_byte = sym_of(st.leftover_bits | {4'b0000, b[7:6]});
               res.words[1].out_byte = sym_of(b[5:0]);
               res.nxt.leftover_bits = '0;
               res.nxt.group_phase   = 2'd0;
               n = 3'd2;
            end
         endcase
         if (item.last_in) begin
            // flush the partial group and pad out to four characters
            if (res.nxt.group_phase == 2'd1) begin
               res.words[1].out_byte = sym_of(res.nxt.leftover_bits);
               res.words[2].out_byte = PAD_CHAR;
               res.words[3].out_byte = PAD_CHAR;
               n = 3'd4;
            end else if (res.nxt.group_phase == 2'd2) begin
               res.words[1].out_byte = sym_of(res.nxt.leftover_bits);
               res.words[2].out_byte = PAD_CHAR;
               n = 3'd3;
            end
            res.nxt = '0;
         end
         for (int k = 0; k < MAX_WORDS; k++) begin
            res.words[k].last_out = item.last_in && (3'(k) == n - 3'd1);
         end
      end else begin
         if (!st.pad_seen) begin
            if (b == PAD_CHAR) begin
               res.nxt.pad_seen = 1'b1;
            end else begin
               bad = vv[SEXTET_W];
               case (st.group_phase)
                  2'd0: begin
                     res.nxt.leftover_bits = v;
                     res.nxt.group_phase   = 2'd1;
                  end
                  2'd1: begin
                     res.words[0].out_byte = {st.leftover_bits, v[5:4]};
                     res.nxt.leftover_bits = {2'b00, v[3:0]};
                     res.nxt.group_phase   = 2'd2;
                     have = 1'b1;
                  end
                  2'd2: begin
                     res.words[0].out_byte = {st.leftover_bits[3:0], v[5:2]};
                     res.nxt.leftover_bits = {4'b0000, v[1:0]};
                     res.nxt.group_phase   = 2'd3;
                     have = 1'b1;
                  end
                  default: begin
                     res.words[0].out_byte = {st.leftover_bits[1:0], v};
                     res.nxt.leftover_bits = '0;
                     res.nxt.group_phase   = 2'd0;
                     have = 1'b1;
                  end
               endcase
            end
         end
         if (item.last_in) begin
            res.nxt = '0;
         end
         res.words[0].bad_char  = bad;
         res.words[0].last_out  = item.last_in;
         res.words[0].empty_res = !have;
         n = (have || item.last_in) ? 3'd1 : 3'd0;
      end
      res.count = n;
   end

endmodule
